@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk_i, rstn_i, lhs, rhs) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk_i, rstn_i, lhs, rhs) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/pia_pkg.sv @@
package pia_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ModeW = 4;
  localparam int unsigned CntW  = 6;

  typedef enum logic [ModeW-1:0] {
    MODE_ADD    = 4'd0,
    MODE_ADDC   = 4'd1,
    MODE_ADDE   = 4'd2,
    MODE_ADDME  = 4'd3,
    MODE_ADDZE  = 4'd4,
    MODE_SUBF   = 4'd5,
    MODE_SUBFC  = 4'd6,
    MODE_SUBFE  = 4'd7,
    MODE_SUBFME = 4'd8,
    MODE_SUBFZE = 4'd9,
    MODE_NEG    = 4'd10,
    MODE_MULLW  = 4'd11,
    MODE_MULHW  = 4'd12,
    MODE_MULHWU = 4'd13,
    MODE_DIVW   = 4'd14,
    MODE_DIVWU  = 4'd15
  } mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture request operands
    logic add_go;    // finish an add-class request
    logic mul_lo;    // multiply low partial products
    logic mul_hi;    // multiply high partial products and finish
    logic div_init;  // set up divider
    logic div_step;  // one radix-2 quotient bit
    logic div_done;  // finish divide
  } pia_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_last;
  } pia_sts_t;

endpackage

@@ hw/rtl/powerpc_integer_alu_core.sv @@
// Channel  | Handshake            | Payload
// in       | in_valid / in_stall  | mode, operand_a, operand_b, a_is_zero, oe, rc
// out      | out_valid / out_stall| result, write, cr0, xer_so/ov/ca
// Add-class requests pass through dispatch to the result register, multiplies
// take two 16x16 partial-product steps, and divides take 32 steps of the radix-2
// restoring divider plus dispatch, setup and finish. One request is in flight.
// Synchronous reset clears XER bits and the controller. A stalled result holds
// and blocks the next request until it is taken.
module powerpc_integer_alu_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [pia_pkg::ModeW-1:0] in_mode,
  input  logic [pia_pkg::DataW-1:0] in_operand_a,
  input  logic [pia_pkg::DataW-1:0] in_operand_b,
  input  logic                      in_a_is_zero,
  input  logic                      in_overflow_enable,
  input  logic                      in_record_cr0,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [pia_pkg::DataW-1:0] out_result,
  output logic                      out_write_result,
  output logic [3:0]                out_cr0_value,
  output logic                      out_cr0_write,
  output logic                      out_xer_so,
  output logic                      out_xer_ov,
  output logic                      out_xer_ca
);
  import pia_pkg::*;

  pia_cmd_t cmd;
  pia_sts_t sts;

  // Sequencing.
  pia_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  // Arithmetic and XER.
  pia_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .in_mode, .in_operand_a, .in_operand_b,
    .in_a_is_zero, .in_overflow_enable, .in_record_cr0, .out_result,
    .out_write_result, .out_cr0_value, .out_cr0_write, .out_xer_so,
    .out_xer_ov, .out_xer_ca
  );
endmodule

@@ hw/rtl/pia_ctrl.sv @@
module pia_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  pia_pkg::pia_sts_t sts,
  output pia_pkg::pia_cmd_t cmd
);
  import pia_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE, ST_DISPATCH, ST_MULHI, ST_DIVINIT, ST_DIV, ST_DIVEND
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   busy;

  // A request is taken once the previous result has left the output register.
  assign busy      = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_stall  = busy;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !busy) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.is_mul) begin
          cmd.mul_lo = 1'b1;
          state_nxt  = ST_MULHI;
        end else if (sts.is_div) begin
          state_nxt = ST_DIVINIT;
        end else begin
          cmd.add_go    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_MULHI: begin
        cmd.mul_hi    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_DIVINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_DIVEND;
      end
      ST_DIVEND: begin
        cmd.div_done  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and the output valid register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_IMPLIES(a_no_take_busy, clk, rst_n, state_r != ST_IDLE, in_stall)
  `ASSERT_NEXT(a_load_leaves_idle, clk, rst_n, cmd.load, state_r == ST_DISPATCH)
  `ASSERT_IMPLIES(a_valid_only_idle, clk, rst_n, out_valid_r && !out_stall,
                  state_r == ST_IDLE)
endmodule

@@ hw/rtl/pia_dp.sv @@
module pia_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pia_pkg::pia_cmd_t         cmd,
  output pia_pkg::pia_sts_t         sts,
  input  logic [pia_pkg::ModeW-1:0] in_mode,
  input  logic [pia_pkg::DataW-1:0] in_operand_a,
  input  logic [pia_pkg::DataW-1:0] in_operand_b,
  input  logic                      in_a_is_zero,
  input  logic                      in_overflow_enable,
  input  logic                      in_record_cr0,
  output logic [pia_pkg::DataW-1:0] out_result,
  output logic                      out_write_result,
  output logic [3:0]                out_cr0_value,
  output logic                      out_cr0_write,
  output logic                      out_xer_so,
  output logic                      out_xer_ov,
  output logic                      out_xer_ca
);
  import pia_pkg::*;
  `include "assert_macros.svh"

  mode_t            mode_r;
  logic [DataW-1:0] a_r, b_r;
  logic             oe_r, rc_r;
  logic             so_r, ov_r, ca_r;
  logic [DataW-1:0] res_r;
  logic             wr_r;
  logic [3:0]       cr_r;
  logic             crw_r;

  // Multiply partial products.
  logic [DataW-1:0]   a_mag, b_mag;
  logic [2*DataW-1:0] ll_r, lh_r, hl_r;
  logic [2*DataW-1:0] hh;
  logic [2*DataW-1:0] prod_u, prod;
  logic               mul_neg_r;

  // Divider.
  logic [DataW-1:0] rem_r, quo_r, div_r;
  logic [CntW-1:0]  cnt_r;
  logic             qneg_r, dbad_r;
  logic [DataW:0]   trial;

  logic [DataW-1:0] add_x, add_y;
  logic             add_c;
  logic [DataW:0]   add_sum;
  logic             add_ov, add_sets_ca;
  logic             is_signed_mul, is_signed_div;

  assign is_signed_mul = (mode_r != MODE_MULHWU);
  assign is_signed_div = (mode_r == MODE_DIVW);

  assign sts.is_mul   = (mode_r == MODE_MULLW) || (mode_r == MODE_MULHW) ||
                        (mode_r == MODE_MULHWU);
  assign sts.is_div   = (mode_r == MODE_DIVW) || (mode_r == MODE_DIVWU);
  assign sts.div_last = (cnt_r == CntW'(DataW - 1));

  // Adder operand selection.
  always_comb begin
    add_x       = a_r;
    add_y       = b_r;
    add_c       = 1'b0;
    add_sets_ca = 1'b1;
    unique case (mode_r)
      MODE_ADD:    add_sets_ca = 1'b0;
      MODE_ADDC:   ;
      MODE_ADDE:   add_c = ca_r;
      MODE_ADDME:  begin add_y = '1; add_c = ca_r; end
      MODE_ADDZE:  begin add_y = '0; add_c = ca_r; end
      MODE_SUBF:   begin add_x = ~a_r; add_c = 1'b1; add_sets_ca = 1'b0; end
      MODE_SUBFC:  begin add_x = ~a_r; add_c = 1'b1; end
      MODE_SUBFE:  begin add_x = ~a_r; add_c = ca_r; end
      MODE_SUBFME: begin add_x = ~a_r; add_y = '1; add_c = ca_r; end
      MODE_SUBFZE: begin add_x = ~a_r; add_y = '0; add_c = ca_r; end
      MODE_NEG:    begin add_x = ~a_r; add_y = '0; add_c = 1'b1; add_sets_ca = 1'b0; end
      default:     add_sets_ca = 1'b0;
    endcase
  end
  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{DataW{1'b0}}, add_c};
  assign add_ov  = (add_x[DataW-1] ^ add_sum[DataW-1]) &
                   (add_y[DataW-1] ^ add_sum[DataW-1]);

  // Magnitudes for signed multiply.
  assign a_mag = (is_signed_mul && a_r[DataW-1]) ? (~a_r + 1'b1) : a_r;
  assign b_mag = (is_signed_mul && b_r[DataW-1]) ? (~b_r + 1'b1) : b_r;
  assign hh    = {32'd0, a_mag[31:16]} * {32'd0, b_mag[31:16]};
  assign prod_u = (hh << 32) + (lh_r << 16) + (hl_r << 16) + ll_r;
  assign prod   = mul_neg_r ? (~prod_u + 1'b1) : prod_u;

  assign trial = {rem_r, quo_r[DataW-1]} - {1'b0, div_r};

  function automatic logic [3:0] cr_of(logic [DataW-1:0] v, logic so);
    logic [3:0] c;
    c = v[DataW-1] ? 4'b1000 : ((v != '0) ? 4'b0100 : 4'b0010);
    return {c[3:1], so};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      so_r <= 1'b0;
      ov_r <= 1'b0;
      ca_r <= 1'b0;
    end else begin
      // Capture request.
      if (cmd.load) begin
        mode_r <= mode_t'(in_mode);
        a_r    <= in_a_is_zero ? '0 : in_operand_a;
        b_r    <= in_operand_b;
        oe_r   <= in_overflow_enable;
        rc_r   <= in_record_cr0;
      end
      // Add-class finish.
      if (cmd.add_go) begin
        res_r <= add_sum[DataW-1:0];
        wr_r  <= 1'b1;
        if (add_sets_ca) ca_r <= add_sum[DataW];
        if (oe_r) begin
          ov_r <= add_ov;
          if (add_ov) so_r <= 1'b1;
        end
        crw_r <= rc_r;
        cr_r  <= rc_r ? cr_of(add_sum[DataW-1:0], so_r | (oe_r & add_ov)) : 4'd0;
      end
      // Multiply: 16x16 partial products, then sum.
      if (cmd.mul_lo) begin
        ll_r      <= {32'd0, a_mag[15:0]} * {32'd0, b_mag[15:0]};
        lh_r      <= {32'd0, a_mag[15:0]} * {32'd0, b_mag[31:16]};
        hl_r      <= {32'd0, a_mag[31:16]} * {32'd0, b_mag[15:0]};
        mul_neg_r <= is_signed_mul & (a_r[DataW-1] ^ b_r[DataW-1]);
      end
      if (cmd.mul_hi) begin
        logic [DataW-1:0] r;
        logic             ovf, lw;
        lw  = (mode_r == MODE_MULLW);
        r   = lw ? prod[DataW-1:0] : prod[2*DataW-1:DataW];
        ovf = (prod[2*DataW-1:DataW] != {DataW{prod[DataW-1]}});
        res_r <= r;
        wr_r  <= 1'b1;
        if (oe_r && lw) begin
          ov_r <= ovf;
          if (ovf) so_r <= 1'b1;
        end
        crw_r <= rc_r;
        cr_r  <= rc_r ? cr_of(r, so_r | (oe_r & lw & ovf)) : 4'd0;
      end
      // Divide setup: magnitudes and fault check.
      if (cmd.div_init) begin
        rem_r  <= '0;
        quo_r  <= (is_signed_div && a_r[DataW-1]) ? (~a_r + 1'b1) : a_r;
        div_r  <= (is_signed_div && b_r[DataW-1]) ? (~b_r + 1'b1) : b_r;
        qneg_r <= is_signed_div & (a_r[DataW-1] ^ b_r[DataW-1]);
        dbad_r <= (b_r == '0) ||
                  (is_signed_div && a_r == 32'h8000_0000 && b_r == '1);
        cnt_r  <= '0;
      end
      // Restoring divide, one quotient bit per cycle.
      if (cmd.div_step) begin
        cnt_r <= cnt_r + 1'b1;
        if (!trial[DataW]) begin
          rem_r <= trial[DataW-1:0];
          quo_r <= {quo_r[DataW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[DataW-2:0], quo_r[DataW-1]};
          quo_r <= {quo_r[DataW-2:0], 1'b0};
        end
      end
      if (cmd.div_done) begin
        logic [DataW-1:0] q;
        q = dbad_r ? '0 : (qneg_r ? (~quo_r + 1'b1) : quo_r);
        res_r <= q;
        wr_r  <= !dbad_r;
        if (oe_r) begin
          ov_r <= dbad_r;
          if (dbad_r) so_r <= 1'b1;
        end
        crw_r <= rc_r & !dbad_r;
        cr_r  <= (rc_r && !dbad_r) ? cr_of(q, so_r) : 4'd0;
      end
    end
  end

  assign out_result       = res_r;
  assign out_write_result = wr_r;
  assign out_cr0_value    = cr_r;
  assign out_cr0_write    = crw_r;
  assign out_xer_so       = so_r;
  assign out_xer_ov       = ov_r;
  assign out_xer_ca       = ca_r;

  `ASSERT_NEXT(a_ov_sets_so, clk, rst_n, ov_r && oe_r && (cmd.add_go || cmd.div_done), so_r)
  `ASSERT_IMPLIES(a_div_step_div, clk, rst_n, cmd.div_step, sts.is_div)
  `ASSERT_NEXT(a_so_sticky, clk, rst_n, so_r, so_r)
endmodule
